// File: design/mspm_pkg.sv
// Shared types and constants for the multi-stream PCM mixer.
// No dependencies.
package mspm_pkg;
  localparam int NUM_STREAMS = 16;
  localparam int FIFO_FRAMES = 16384;
  localparam int MAX_MIX_RUN = 64;
  localparam int SID_W = 4;
  localparam int PTR_W = 14;
  localparam int CNT_W = 15;

  localparam logic [2:0] OP_OPEN   = 3'd0;
  localparam logic [2:0] OP_CLOSE  = 3'd1;
  localparam logic [2:0] OP_PUSH   = 3'd2;
  localparam logic [2:0] OP_MIX    = 3'd3;
  localparam logic [2:0] OP_PAUSE  = 3'd4;
  localparam logic [2:0] OP_RESUME = 3'd5;
  localparam logic [2:0] OP_FLUSH  = 3'd6;
  localparam logic [2:0] OP_STATUS = 3'd7;

  localparam logic [1:0] KIND_RESP = 2'd0;
  localparam logic [1:0] KIND_PASS = 2'd1;
  localparam logic [1:0] KIND_MIX  = 2'd2;

  localparam logic [0:0] REG_TARGET = 1'b0;
  localparam logic [0:0] REG_CHUNK  = 1'b1;

  typedef struct packed {
    logic [2:0]         operation;
    logic [3:0]         stream_id;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [15:0]        hw_queued_frames;
    logic               hw_paused;
    logic               hw_running;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               last_frame;
    logic               error_flag;
    logic [3:0]         granted_stream;
    logic [15:0]        queued_frames;
    logic               paused_flag;
    logic               running_flag;
    logic               flush_hardware;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic             cmd;       // execute non-mix command
    logic             eval;      // register mix plan
    logic             clr;       // clear accumulators, start stream scan
    logic             step;      // visit scan stream
    logic             emit;      // output mixed frame
    logic             last;
    logic [SID_W-1:0] scan;
  } dp_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic       mix_go;
    logic [6:0] frames;
  } dp_sts_t;
endpackage

// File: design/mspm_ctrl.sv
// Sequencer for the mixer: command dispatch, mix frame and stream scan loops.
// Depends on mspm_pkg.
module mspm_ctrl import mspm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  in_word_t in_word,
  input  dp_sts_t  sts,
  output logic     busy,
  output dp_ctl_t  ctl
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PLAN = 3'd1;
  localparam logic [2:0] ST_CLR  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_WAIT = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0]       state, state_next;
  logic [SID_W-1:0] scan, scan_next;
  logic [6:0]       fcnt, fcnt_next;
  logic [6:0]       total, total_next;

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    scan_next = scan;
    fcnt_next = fcnt;
    total_next = total;
    ctl = '0;
    ctl.scan = scan;
    ctl.last = (fcnt + 7'd1 == total);
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (in_word.operation == OP_MIX) begin
            ctl.eval = 1'b1;
            state_next = ST_PLAN;
          end else begin
            ctl.cmd = 1'b1;
          end
        end
      end
      ST_PLAN: begin
        if (sts.mix_go) begin
          total_next = sts.frames;
          fcnt_next = '0;
          state_next = ST_CLR;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_CLR: begin
        ctl.clr = 1'b1;
        scan_next = '0;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        ctl.step = 1'b1;
        scan_next = scan + 1'b1;
        if (scan == SID_W'(NUM_STREAMS - 1)) state_next = ST_WAIT;
      end
      ST_WAIT: state_next = ST_EMIT;
      ST_EMIT: begin
        ctl.emit = 1'b1;
        fcnt_next = fcnt + 7'd1;
        state_next = (fcnt + 7'd1 == total) ? ST_IDLE : ST_CLR;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      scan <= '0;
      fcnt <= '0;
      total <= '0;
    end else begin
      state <= state_next;
      scan <= scan_next;
      fcnt <= fcnt_next;
      total <= total_next;
    end
  end

  a_emit_in_mix: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> $past(state) == ST_WAIT) else $error("emit out of order");
  a_scan_wrap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && scan == SID_W'(NUM_STREAMS - 1)) |=> state == ST_WAIT)
    else $error("scan did not end");
  a_no_zero_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PLAN && sts.mix_go) |-> sts.frames != 7'd0)
    else $error("empty mix run");
endmodule

// File: design/mspm_dp.sv
// Datapath: stream tables, frame memory, accumulators, result register.
// Depends on mspm_pkg.
module mspm_dp import mspm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_word_t  in_word,
  input  dp_ctl_t   ctl,
  input  logic      cfg_we,
  input  logic      cfg_idx,
  input  logic [14:0] cfg_data,
  output dp_sts_t   sts,
  output logic      res_valid,
  output out_word_t res
);
  localparam int AW = SID_W + PTR_W;

  logic [31:0] mem [0:NUM_STREAMS*FIFO_FRAMES-1];
  logic [PTR_W-1:0] head [NUM_STREAMS];
  logic [CNT_W-1:0] cnt  [NUM_STREAMS];
  logic [NUM_STREAMS-1:0] open_q, paused_q;
  logic [14:0] target;
  logic [6:0]  chunk;
  logic [31:0] rd_data;
  logic        rd_en;
  logic signed [20:0] acc_l, acc_r;
  logic        mix_go;
  logic [6:0]  frames;

  // stream decode
  logic             valid;
  logic [SID_W-1:0] sid;
  logic [4:0]       n_open;
  logic             one_open, fifo_empty;
  logic [SID_W-1:0] free_id;
  logic             have_free;

  assign sid = in_word.stream_id;
  assign valid = open_q[sid];
  assign fifo_empty = (cnt[sid] == '0);

  always_comb begin
    n_open = '0;
    for (int i = 0; i < NUM_STREAMS; i++) n_open = n_open + 5'(open_q[i]);
  end
  assign one_open = (n_open == 5'd1);

  always_comb begin
    free_id = '0;
    have_free = 1'b0;
    for (int i = NUM_STREAMS - 1; i >= 0; i--)
      if (!open_q[i]) begin
        free_id = SID_W'(i);
        have_free = 1'b1;
      end
  end

  // mix plan
  logic              queued;
  logic [CNT_W-1:0]  max_cnt;
  logic [15:0]       budget;
  logic [6:0]        chk;
  logic [15:0]       lim;
  always_comb begin
    queued = 1'b0;
    max_cnt = '0;
    for (int i = 0; i < NUM_STREAMS; i++) begin
      if (open_q[i] && cnt[i] != '0) queued = 1'b1;
      if (open_q[i] && !paused_q[i] && cnt[i] > max_cnt) max_cnt = cnt[i];
    end
  end
  always_comb begin
    chk = (chunk > 7'(MAX_MIX_RUN)) ? 7'(MAX_MIX_RUN) : chunk;
    budget = 16'(target) - in_word.hw_queued_frames;
    lim = (budget > 16'(chk)) ? 16'(chk) : budget;
  end

  assign sts.mix_go = mix_go;
  assign sts.frames = frames;

  // per-stream scan step
  logic             take;
  assign take = ctl.step && open_q[ctl.scan] && !paused_q[ctl.scan]
                && cnt[ctl.scan] != '0;

  logic [PTR_W-1:0] tail;
  assign tail = head[sid] + PTR_W'(cnt[sid]);

  logic push_wr;
  assign push_wr = ctl.cmd && in_word.operation == OP_PUSH && valid
                   && !(one_open && fifo_empty)
                   && cnt[sid] < CNT_W'(FIFO_FRAMES);

  always_ff @(posedge clk) begin
    if (push_wr) mem[{sid, tail}] <= {in_word.right_sample, in_word.left_sample};
    if (take) rd_data <= mem[AW'({ctl.scan, head[ctl.scan]})];
  end

  logic signed [16:0] sl, sr;
  assign sl = 17'(signed'(rd_data[15:0]));
  assign sr = 17'(signed'(rd_data[31:16]));

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_en <= 1'b0;
    end else begin
      rd_en <= take;
    end
    if (ctl.clr) begin
      acc_l <= '0;
      acc_r <= '0;
    end else if (rd_en) begin
      acc_l <= acc_l + 21'(sl);
      acc_r <= acc_r + 21'(sr);
    end
  end

  function automatic logic [15:0] sat(input logic signed [20:0] v);
    if (v > 21'sd32767) return 16'h7FFF;
    if (v < -21'sd32768) return 16'h8000;
    return v[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      mix_go <= !((!queued && n_open <= 5'd1) || in_word.hw_paused
                  || 16'(target) <= in_word.hw_queued_frames
                  || lim == '0 || max_cnt == '0);
      frames <= (16'(max_cnt) > lim) ? lim[6:0] : max_cnt[6:0];
    end
  end

  // tables and result
  out_word_t r;
  always_comb begin
    r = '0;
    unique case (in_word.operation)
      OP_OPEN: begin
        r.error_flag = !have_free;
        r.granted_stream = free_id;
      end
      OP_CLOSE: begin
        r.error_flag = !valid;
        r.flush_hardware = valid ? (n_open == 5'd1) : (n_open == 5'd0);
      end
      OP_PUSH: begin
        if (!valid) r.error_flag = 1'b1;
        else if (one_open && fifo_empty) begin
          r.kind = KIND_PASS;
          r.left_out = in_word.left_sample;
          r.right_out = in_word.right_sample;
        end else if (cnt[sid] >= CNT_W'(FIFO_FRAMES)) r.error_flag = 1'b1;
      end
      OP_STATUS: begin
        if (!valid) r.error_flag = 1'b1;
        else begin
          r.queued_frames = (one_open && fifo_empty) ? in_word.hw_queued_frames
                                                     : 16'(cnt[sid]);
          r.paused_flag = paused_q[sid];
          r.running_flag = !fifo_empty || in_word.hw_running;
        end
      end
      default: r.error_flag = !valid;
    endcase
  end

  out_word_t mix_word;
  always_comb begin
    mix_word = '0;
    mix_word.kind = KIND_MIX;
    mix_word.left_out = sat(acc_l);
    mix_word.right_out = sat(acc_r);
    mix_word.last_frame = ctl.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      open_q <= '0;
      paused_q <= '0;
      target <= 15'd8192;
      chunk <= 7'd64;
      for (int i = 0; i < NUM_STREAMS; i++) begin
        head[i] <= '0;
        cnt[i] <= '0;
      end
    end else begin
      res_valid <= ctl.cmd || ctl.emit;
      if (cfg_we) begin
        if (cfg_idx == REG_TARGET) target <= cfg_data;
        else chunk <= cfg_data[6:0];
      end
      if (take) begin
        head[ctl.scan] <= head[ctl.scan] + 1'b1;
        cnt[ctl.scan] <= cnt[ctl.scan] - 1'b1;
      end
      if (ctl.cmd) begin
        unique case (in_word.operation)
          OP_OPEN: if (have_free) begin
            open_q[free_id] <= 1'b1;
            paused_q[free_id] <= 1'b0;
            head[free_id] <= '0;
            cnt[free_id] <= '0;
          end
          OP_CLOSE: if (valid) begin
            open_q[sid] <= 1'b0;
            paused_q[sid] <= 1'b0;
            head[sid] <= '0;
            cnt[sid] <= '0;
          end
          OP_PUSH: if (push_wr) cnt[sid] <= cnt[sid] + 1'b1;
          OP_PAUSE: if (valid) paused_q[sid] <= 1'b1;
          OP_RESUME: if (valid) paused_q[sid] <= 1'b0;
          OP_FLUSH: if (valid) begin
            head[sid] <= '0;
            cnt[sid] <= '0;
          end
          default: ;
        endcase
      end
    end
    if (ctl.emit) begin
      res <= mix_word;
    end else if (ctl.cmd) begin
      res <= r;
    end
  end

  a_cmd_emit_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctl.cmd && ctl.emit)) else $error("command during mix");
  a_take_nonempty: assert property (@(posedge clk) disable iff (rst)
    take |=> cnt[$past(ctl.scan)] == $past(cnt[ctl.scan]) - 1'b1)
    else $error("count not decremented");
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (ctl.cmd || ctl.emit) |=> res_valid) else $error("result lost");
endmodule

// File: design/multi_stream_pcm_mixer_unit.sv
// Multi-stream PCM mixer: command port, config port, result strobe.
// Depends on mspm_pkg, mspm_ctrl, mspm_dp.
//
// Usage: drive in_word and raise start while busy is low; the word is taken
// on that edge. Open, close, push, pause, resume, flush and status return one
// result word in the following cycle, marked by out_valid, and the block is ready
// again in the next cycle (one word per cycle).
// A mix returns 0 to 64 mixed frames. It first registers the mix plan; each
// frame then clears the accumulators, scans the 16 stream heads through the
// single frame memory read port, accumulates and saturates. busy stays high
// through the run; a skipped mix holds busy for one cycle.
// out_valid flags each result for exactly one cycle; the receiver cannot stall,
// so it must take every strobe.
// Configuration: cfg_we with cfg_index 0 (target) or 1 (chunk), only while
// idle. Reset (rst, synchronous) closes all streams, empties all FIFOs and
// loads target 8192 and chunk 64. Frame memory contents need no clearing.
module multi_stream_pcm_mixer_unit import mspm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  in_word_t    in_word,
  output logic        busy,
  output logic        out_valid,
  output out_word_t   out_word,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [14:0] cfg_data
);
  dp_ctl_t ctl;
  dp_sts_t sts;

  mspm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .in_word(in_word),
    .sts(sts), .busy(busy), .ctl(ctl)
  );

  mspm_dp u_dp (
    .clk(clk), .rst(rst), .in_word(in_word), .ctl(ctl),
    .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
    .sts(sts), .res_valid(out_valid), .res(out_word)
  );
endmodule

// File: bench/multi_stream_pcm_mixer_unit_tb.sv
// Self-checking bench for multi_stream_pcm_mixer_unit: directed table, all-open run, random words.
// Checks results against typed rows or the in-bench predictor. Depends on mspm_pkg and the RTL.
`timescale 1ns / 1ps

module multi_stream_pcm_mixer_unit_tb;
  import mspm_pkg::*;

  localparam int QUIET_LIMIT = 20000;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  in_word_t    in_word = '0;
  logic        busy;
  logic        out_valid;
  out_word_t   out_word;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [14:0] cfg_data = '0;

  logic        row_typed = 1'b0;
  out_word_t   row_exp = '0;

  multi_stream_pcm_mixer_unit DUT (
    .clk(clk), .rst(rst), .start(start), .in_word(in_word), .busy(busy),
    .out_valid(out_valid), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // mixer state as seen by the predictor
  bit [31:0]   frame_q [NUM_STREAMS][$];
  bit          sopen [NUM_STREAMS];
  bit          spaused [NUM_STREAMS];
  int unsigned target_frames = 8192;
  int unsigned chunk_frames = 64;

  out_word_t   pending_words [$];
  int          n_fail = 0;
  int          n_in = 0;
  int          n_out = 0;
  int          n_mixed = 0;
  int          quiet = 0;

  function automatic int open_count();
    int n;
    n = 0;
    for (int s = 0; s < NUM_STREAMS; s++) if (sopen[s]) n++;
    return n;
  endfunction

  function automatic logic signed [15:0] sat16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  task automatic mixer_predict(input in_word_t w);
    out_word_t r;
    int        id;
    bit        ok;
    bit        any_q;
    int        budget;
    int        ch;
    int        frames;
    int        acc_l;
    int        acc_r;
    int        f;
    bit [31:0] wd;
    r = '0;
    id = w.stream_id;
    ok = sopen[id];
    case (w.operation)
      OP_OPEN: begin
        for (f = 0; f < NUM_STREAMS; f++) if (!sopen[f]) break;
        if (f == NUM_STREAMS) r.error_flag = 1'b1;
        else begin
          frame_q[f].delete();
          spaused[f] = 1'b0;
          sopen[f] = 1'b1;
          r.granted_stream = f[3:0];
        end
        pending_words.push_back(r);
      end
      OP_CLOSE: begin
        if (ok) begin
          frame_q[id].delete();
          spaused[id] = 1'b0;
          sopen[id] = 1'b0;
        end else r.error_flag = 1'b1;
        r.flush_hardware = (open_count() == 0);
        pending_words.push_back(r);
      end
      OP_PUSH: begin
        if (!ok) r.error_flag = 1'b1;
        else if (open_count() == 1 && frame_q[id].size() == 0) begin
          r.kind = KIND_PASS;
          r.left_out = w.left_sample;
          r.right_out = w.right_sample;
        end else if (frame_q[id].size() >= FIFO_FRAMES) r.error_flag = 1'b1;
        else frame_q[id].push_back({w.right_sample, w.left_sample});
        pending_words.push_back(r);
      end
      OP_MIX: begin
        any_q = 1'b0;
        for (int s = 0; s < NUM_STREAMS; s++)
          if (sopen[s] && frame_q[s].size() != 0) any_q = 1'b1;
        if ((any_q || open_count() > 1) && !w.hw_paused && w.hw_queued_frames < target_frames)
        begin
          budget = target_frames - w.hw_queued_frames;
          ch = (chunk_frames > MAX_MIX_RUN) ? MAX_MIX_RUN : chunk_frames;
          if (budget > ch) budget = ch;
          frames = 0;
          for (int s = 0; s < NUM_STREAMS; s++)
            if (sopen[s] && !spaused[s] && frame_q[s].size() > frames)
              frames = frame_q[s].size();
          if (frames > budget) frames = budget;
          for (f = 0; f < frames; f++) begin
            acc_l = 0;
            acc_r = 0;
            for (int s = 0; s < NUM_STREAMS; s++) begin
              if (sopen[s] && !spaused[s] && frame_q[s].size() != 0) begin
                wd = frame_q[s].pop_front();
                acc_l += $signed(wd[15:0]);
                acc_r += $signed(wd[31:16]);
              end
            end
            r = '0;
            r.kind = KIND_MIX;
            r.left_out = sat16(acc_l);
            r.right_out = sat16(acc_r);
            r.last_frame = (f == frames - 1);
            pending_words.push_back(r);
          end
        end
      end
      OP_PAUSE, OP_RESUME, OP_FLUSH: begin
        if (!ok) r.error_flag = 1'b1;
        else if (w.operation == OP_PAUSE) spaused[id] = 1'b1;
        else if (w.operation == OP_RESUME) spaused[id] = 1'b0;
        else frame_q[id].delete();
        pending_words.push_back(r);
      end
      default: begin
        if (!ok) r.error_flag = 1'b1;
        else begin
          if (open_count() == 1 && frame_q[id].size() == 0)
            r.queued_frames = w.hw_queued_frames;
          else r.queued_frames = 16'(frame_q[id].size());
          r.paused_flag = spaused[id];
          r.running_flag = (frame_q[id].size() != 0) || w.hw_running;
        end
        pending_words.push_back(r);
      end
    endcase
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    n_fail++;
  endtask

  task automatic compare_word(input out_word_t g, input out_word_t e);
    if (g.kind !== e.kind) report("kind", g.kind, e.kind);
    if (g.left_out !== e.left_out) report("left_out", g.left_out, e.left_out);
    if (g.right_out !== e.right_out) report("right_out", g.right_out, e.right_out);
    if (g.last_frame !== e.last_frame) report("last_frame", g.last_frame, e.last_frame);
    if (g.error_flag !== e.error_flag) report("error_flag", g.error_flag, e.error_flag);
    if (g.granted_stream !== e.granted_stream)
      report("granted_stream", g.granted_stream, e.granted_stream);
    if (g.queued_frames !== e.queued_frames)
      report("queued_frames", g.queued_frames, e.queued_frames);
    if (g.paused_flag !== e.paused_flag) report("paused_flag", g.paused_flag, e.paused_flag);
    if (g.running_flag !== e.running_flag)
      report("running_flag", g.running_flag, e.running_flag);
    if (g.flush_hardware !== e.flush_hardware)
      report("flush_hardware", g.flush_hardware, e.flush_hardware);
  endtask

  always @(posedge clk) begin
    int nb;
    if (!rst) begin
      if (cfg_we) begin
        if (cfg_index == REG_TARGET) target_frames = cfg_data;
        else chunk_frames = cfg_data[6:0];
      end
      if (start && !busy) begin
        nb = pending_words.size();
        mixer_predict(in_word);
        if (row_typed && pending_words.size() == nb + 1) pending_words[nb] = row_exp;
        n_in++;
      end
      if (out_valid) begin
        n_out++;
        if (out_word.kind == KIND_MIX) n_mixed++;
        if (pending_words.size() == 0) begin
          $display("unexpected result word at %0t", $time);
          n_fail++;
        end else compare_word(out_word, pending_words.pop_front());
      end
    end
  end

  // watchdog: no word moving in either direction for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || out_valid || cfg_we) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("** multi_stream_pcm_mixer_unit: FAILED **");
      $finish;
    end
  end

  function automatic in_word_t iw(logic [2:0] op, int id, int l, int r, int q,
                                  bit p, bit run);
    in_word_t w;
    w.operation = op;
    w.stream_id = id[3:0];
    w.left_sample = l[15:0];
    w.right_sample = r[15:0];
    w.hw_queued_frames = q[15:0];
    w.hw_paused = p;
    w.hw_running = run;
    return w;
  endfunction

  function automatic out_word_t ow(logic [1:0] k, int l, int r, bit err, int gs, int q,
                                   bit pf, bit rf, bit fh);
    out_word_t e;
    e = '0;
    e.kind = k;
    e.left_out = l[15:0];
    e.right_out = r[15:0];
    e.error_flag = err;
    e.granted_stream = gs[3:0];
    e.queued_frames = q[15:0];
    e.paused_flag = pf;
    e.running_flag = rf;
    e.flush_hardware = fh;
    return e;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(input in_word_t w, input int gap, input bit typed, input out_word_t e);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    row_typed <= typed;
    row_exp <= e;
    do @(posedge clk); while (busy);
  endtask

  task automatic settle();
    start <= 1'b0;
    row_typed <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [14:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int rand_sample();
    case ($urandom_range(0, 7))
      0: return 32767;
      1: return -32768;
      2: return $urandom_range(0, 200) - 100;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic random_word(input bit no_gaps);
    int        r;
    int        ids [$];
    int        id;
    logic [2:0] op;
    int        q;
    for (int s = 0; s < NUM_STREAMS; s++) if (sopen[s]) ids.push_back(s);
    r = $urandom_range(0, 99);
    if (ids.size() == 0 && r < 70) op = OP_OPEN;
    else if (r < 42) op = OP_PUSH;
    else if (r < 58) op = OP_MIX;
    else if (r < 68) op = (ids.size() < 4) ? OP_OPEN : OP_PUSH;
    else if (r < 74) op = OP_CLOSE;
    else if (r < 80) op = OP_PAUSE;
    else if (r < 86) op = OP_RESUME;
    else if (r < 90) op = OP_FLUSH;
    else if (r < 96) op = OP_STATUS;
    else op = 3'($urandom_range(0, 7));
    if (ids.size() != 0 && $urandom_range(0, 9) < 8) id = ids[$urandom_range(0, ids.size() - 1)];
    else id = $urandom_range(0, 15);
    if ($urandom_range(0, 9) < 8) q = $urandom_range(0, 40);
    else q = $urandom_range(0, 65535);
    send(iw(op, id, rand_sample(), rand_sample(), q, $urandom_range(0, 9) == 0,
            1'($urandom_range(0, 1))), no_gaps ? 0 : pick_gap(), 1'b0, '0);
  endtask

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t e;
  } row_t;

  row_t        rows [$];
  int          tgt_set [5] = '{16384, 100, 0, 20, 32767};
  int          chunk_set [5] = '{64, 1, 127, 0, 5};

  task automatic add(input in_word_t w, input bit typed, input out_word_t e);
    row_t rw;
    rw.w = w;
    rw.typed = typed;
    rw.e = e;
    rows.push_back(rw);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add(iw(OP_STATUS, 0, 0, 0, 0, 0, 0), 1, ow(KIND_RESP, 0, 0, 1, 0, 0, 0, 0, 0));
    add(iw(OP_CLOSE, 3, 0, 0, 0, 0, 0), 1, ow(KIND_RESP, 0, 0, 1, 0, 0, 0, 0, 1));
    add(iw(OP_PUSH, 0, 5, 5, 0, 0, 0), 1, ow(KIND_RESP, 0, 0, 1, 0, 0, 0, 0, 0));
    add(iw(OP_MIX, 0, 0, 0, 0, 0, 0), 0, '0);
    add(iw(OP_OPEN, 9, 0, 0, 0, 0, 0), 1, ow(KIND_RESP, 0, 0, 0, 0, 0, 0, 0, 0));
    add(iw(OP_PUSH, 0, 32767, -32768, 0, 0, 0), 1,
        ow(KIND_PASS, 32767, -32768, 0, 0, 0, 0, 0, 0));
    add(iw(OP_STATUS, 0, 0, 0, 65535, 0, 1), 1, ow(KIND_RESP, 0, 0, 0, 0, 65535, 0, 1, 0));
    add(iw(OP_OPEN, 0, 0, 0, 0, 0, 0), 1, ow(KIND_RESP, 0, 0, 0, 1, 0, 0, 0, 0));
    add(iw(OP_PUSH, 0, 32767, -32768, 0, 0, 0), 0, '0);
    add(iw(OP_PUSH, 1, 32767, -32768, 0, 0, 0), 0, '0);
    add(iw(OP_PUSH, 0, -1, 1, 0, 0, 0), 0, '0);
    add(iw(OP_PAUSE, 1, 0, 0, 0, 0, 0), 0, '0);
    add(iw(OP_STATUS, 1, 0, 0, 0, 0, 0), 1, ow(KIND_RESP, 0, 0, 0, 0, 1, 1, 1, 0));
    add(iw(OP_RESUME, 1, 0, 0, 0, 0, 0), 0, '0);
    add(iw(OP_MIX, 0, 0, 0, 0, 1, 0), 0, '0);
    add(iw(OP_MIX, 0, 0, 0, 8192, 0, 0), 0, '0);
    add(iw(OP_MIX, 0, 0, 0, 0, 0, 1), 0, '0);
    add(iw(OP_FLUSH, 0, 0, 0, 0, 0, 0), 0, '0);
    add(iw(OP_PAUSE, 2, 0, 0, 0, 0, 0), 1, ow(KIND_RESP, 0, 0, 1, 0, 0, 0, 0, 0));
    add(iw(OP_RESUME, 15, 0, 0, 0, 0, 0), 1, ow(KIND_RESP, 0, 0, 1, 0, 0, 0, 0, 0));
    add(iw(OP_FLUSH, 15, 0, 0, 0, 0, 0), 1, ow(KIND_RESP, 0, 0, 1, 0, 0, 0, 0, 0));
    add(iw(OP_CLOSE, 1, 0, 0, 0, 0, 0), 1, ow(KIND_RESP, 0, 0, 0, 0, 0, 0, 0, 0));
    add(iw(OP_CLOSE, 0, 0, 0, 0, 0, 0), 1, ow(KIND_RESP, 0, 0, 0, 0, 0, 0, 0, 1));
    foreach (rows[i]) send(rows[i].w, pick_gap(), rows[i].typed, rows[i].e);
    settle();

    // every stream open, then one open too many, pushes on every stream, a wide mix and closes
    for (int s = 0; s < NUM_STREAMS; s++)
      send(iw(OP_OPEN, 0, 0, 0, 0, 0, 0), 0, 1, ow(KIND_RESP, 0, 0, 0, s, 0, 0, 0, 0));
    send(iw(OP_OPEN, 0, 0, 0, 0, 0, 0), 0, 1, ow(KIND_RESP, 0, 0, 1, 0, 0, 0, 0, 0));
    for (int s = 0; s < NUM_STREAMS; s++) begin
      send(iw(OP_PUSH, s, rand_sample(), rand_sample(), 0, 0, 0), pick_gap(), 0, '0);
      send(iw(OP_PUSH, s, 3000, -3000, 0, 0, 0), 0, 0, '0);
    end
    send(iw(OP_MIX, 0, 0, 0, 0, 0, 0), 0, 0, '0);
    for (int s = 0; s < NUM_STREAMS; s++) send(iw(OP_CLOSE, s, 0, 0, 0, 0, 0), 0, 0, '0);
    settle();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_TARGET, 15'(tgt_set[ph]));
      write_reg(REG_CHUNK, {8'($urandom_range(0, 255)), 7'(chunk_set[ph])});
      repeat (34) random_word(ph == 3);
      settle();
    end
    write_reg(REG_TARGET, 15'd8192);
    write_reg(REG_CHUNK, 15'd64);
    repeat (20) random_word(1'b0);
    settle();
    repeat (50) @(posedge clk);

    $display("%0d command words in, %0d result words out (%0d mixed frames)",
             n_in, n_out, n_mixed);
    $display("covered errors, passthrough, all streams open, six register settings");
    if (n_fail == 0 && pending_words.size() == 0) begin
      $display("** multi_stream_pcm_mixer_unit: PASSED **");
    end else begin
      $display("%0d mismatches, %0d words still expected", n_fail, pending_words.size());
      $display("** multi_stream_pcm_mixer_unit: FAILED **");
    end
    $finish;
  end
endmodule

// File: files.f
design/mspm_pkg.sv
design/mspm_ctrl.sv
design/mspm_dp.sv
design/multi_stream_pcm_mixer_unit.sv
bench/multi_stream_pcm_mixer_unit_tb.sv
